// ----- rtl/bawm_pkg.sv -----
// Shared constants, types and helpers of the binary activation window mean block.
package bawm_pkg;

  localparam int PIX_W         = 16;
  localparam int MAG_W         = 15;
  localparam int MAG_MAX       = 32767;
  localparam int CFG_W         = 11;
  localparam int CFG_IDX_W     = 2;
  localparam int ROW_W         = 10;
  localparam int COL_OUT_W     = 10;
  localparam int BETA_W        = 15;
  localparam int MAX_HEIGHT    = 1024;
  localparam int DIM_RESET     = 28;
  localparam int DEF_WIN_ROWS  = 3;
  localparam int DEF_WIN_COLS  = 3;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Per-pixel side information that travels alongside the datapath
  typedef struct packed {
    logic                 sign_negative;
    logic                 beta_valid;
    logic [ROW_W-1:0]     beta_row;
    logic [COL_OUT_W-1:0] beta_col;
  } meta_t;

  typedef struct packed {
    logic                 sign_negative;
    logic                 beta_valid;
    logic [BETA_W-1:0]    beta;
    logic [ROW_W-1:0]     beta_row;
    logic [COL_OUT_W-1:0] beta_col;
  } result_t;

  // Absolute value of a Q1.15 sample; the most negative code saturates
  function automatic logic [MAG_W-1:0] magnitude(input logic [PIX_W-1:0] raw);
    logic [PIX_W-1:0] neg;
    neg = ~raw + PIX_W'(1);
    if (!raw[PIX_W-1]) begin
      return raw[MAG_W-1:0];
    end else if (raw == {1'b1, {(PIX_W-1){1'b0}}}) begin
      return MAG_W'(MAG_MAX);
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/bawm_pixel_if.sv -----
// Pixel input channel: valid/ready handshake with pixel and start flag.
interface bawm_pixel_if;
  import bawm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel;
  logic                    start_image;

  modport source (output valid, output pixel, output start_image, input ready);
  modport sink   (input valid, input pixel, input start_image, output ready);
endinterface

// ----- rtl/bawm_result_if.sv -----
// Result output channel: valid/ready handshake with sign bit and window mean.
interface bawm_result_if;
  import bawm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 sign_negative;
  logic                 beta_valid;
  logic [BETA_W-1:0]    beta;
  logic [ROW_W-1:0]     beta_row;
  logic [COL_OUT_W-1:0] beta_col;

  modport source (output valid, output sign_negative, output beta_valid, output beta,
                  output beta_row, output beta_col, input ready);
  modport sink   (input valid, input sign_negative, input beta_valid, input beta,
                  input beta_row, input beta_col, output ready);
endinterface

// ----- rtl/bawm_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
interface bawm_cfg_if;
  import bawm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/bawm_line_store.sv -----
// Line store of absolute values, one word per column holding every window row.
module bawm_line_store #(
  parameter int WIN_ROWS  = bawm_pkg::DEF_WIN_ROWS,
  parameter int MAX_WIDTH = bawm_pkg::DEF_MAX_WIDTH,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int SW        = (WIN_ROWS > 1) ? $clog2(WIN_ROWS) : 1,
  parameter int VW        = bawm_pkg::MAG_W + $clog2(WIN_ROWS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [CW-1:0]            rd_col,
  input  logic                     wr_valid,
  input  logic [CW-1:0]            wr_col,
  input  logic [SW-1:0]            wr_slot,
  input  logic [bawm_pkg::MAG_W-1:0] wr_mag,
  output logic [VW-1:0]            vsum
);
  import bawm_pkg::*;

  typedef logic [WIN_ROWS-1:0][MAG_W-1:0] word_t;

  word_t         mem [MAX_WIDTH];
  word_t         rdata;
  word_t         merged;
  word_t         fwd_word;
  logic          fwd_valid;
  logic [CW-1:0] fwd_col;

  always_ff @(posedge clk) begin
    rdata <= mem[rd_col];
    if (wr_valid) begin
      mem[wr_col] <= merged;
    end
  end

  // The previous beat writes as this one reads: take its word instead
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_valid;
    end
    fwd_col  <= wr_col;
    fwd_word <= merged;
  end

  always_comb begin
    merged = (fwd_valid && fwd_col == wr_col) ? fwd_word : rdata;
    for (int r = 0; r < WIN_ROWS; r++) begin
      if (SW'(r) == wr_slot) begin
        merged[r] = wr_mag;
      end
    end
    vsum = '0;
    for (int r = 0; r < WIN_ROWS; r++) begin
      vsum = vsum + VW'(merged[r]);
    end
  end

endmodule

// ----- rtl/bawm_cell.sv -----
// One column cell: holds a vertical sum, passes it on and adds it to the running total.
module bawm_cell #(
  parameter int VW = 17,
  parameter int TW = 19
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic [VW-1:0] vsum_in,
  input  logic [TW-1:0] part_in,
  output logic [VW-1:0] vsum_out,
  output logic [TW-1:0] part_out
);

  logic [VW-1:0] vsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsum <= '0;
    end else if (shift) begin
      vsum <= vsum_in;
    end
  end

  assign vsum_out = vsum;
  assign part_out = part_in + TW'(vsum);

endmodule

// ----- rtl/bawm_mean_div.sv -----
// Division of the window total by the window size: reciprocal multiply and one correction.
module bawm_mean_div #(
  parameter int WIN_SIZE = 9,
  parameter int TW       = 19
) (
  input  logic                        clk,
  input  logic [TW-1:0]               total_in,
  output logic [bawm_pkg::BETA_W-1:0] q
);
  import bawm_pkg::*;

  localparam int SH    = TW;
  localparam int RW    = SH + 1;
  localparam int RECIP = (2 ** SH) / WIN_SIZE;
  localparam int NW    = $clog2(WIN_SIZE + 1);
  localparam int PW    = TW + RW;

  logic [TW-1:0]    tot1;
  logic [TW-1:0]    tot2;
  logic [TW-1:0]    qest;
  logic [PW-1:0]    prod;
  logic [TW+NW-1:0] back;
  logic [TW-1:0]    rem;
  logic [TW-1:0]    qfix;

  // Estimate is exact or one short since 2^SH exceeds any total
  assign prod = PW'(tot1) * PW'(RW'(RECIP));

  always_ff @(posedge clk) begin
    tot1 <= total_in;
    tot2 <= tot1;
    qest <= prod[SH +: TW];
  end

  always_comb begin
    back = (TW+NW)'(qest) * (TW+NW)'(WIN_SIZE);
    rem  = tot2 - back[TW-1:0];
    qfix = (rem >= TW'(WIN_SIZE)) ? qest + TW'(1) : qest;
    q    = qfix[BETA_W-1:0];
  end

endmodule

// ----- rtl/binary_activation_window_mean_abs.sv -----
// Top level: binarises a pixel stream and gives the mean absolute value of each window.
//
//   channel   dir   handshake      payload
//   pixels    in    valid/ready    pixel[15:0] signed, start_image
//   results   out   valid/ready    sign_negative, beta_valid, beta[14:0], beta_row, beta_col
//   cfg       in    valid/ready    index[1:0] (0 image_width, 1 image_height), data[10:0]
//
// One pixel a cycle sustained while the result queue has room; a result reaches the queue through
// the line store's registered read, the column cell chain and the two-stage divider.
// The line store has one read and one write port; the previous beat's word is forwarded.
// Synchronous active-high reset clears positions, cell sums and the result queue and sets
// both size registers to 28. The line store gets no clearing pass.
// A stalled result side lets up to eight beats in flight or queued before ready drops.
module binary_activation_window_mean_abs #(
  parameter int WIN_ROWS  = bawm_pkg::DEF_WIN_ROWS,
  parameter int WIN_COLS  = bawm_pkg::DEF_WIN_COLS,
  parameter int MAX_WIDTH = bawm_pkg::DEF_MAX_WIDTH
) (
  input logic          clk,
  input logic          rst,
  bawm_pixel_if.sink   pixels,
  bawm_result_if.source results,
  bawm_cfg_if.sink     cfg
);
  import bawm_pkg::*;

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int WW       = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HW       = ROW_W + 1;
  localparam int SW       = (WIN_ROWS > 1) ? $clog2(WIN_ROWS) : 1;
  localparam int VW       = MAG_W + $clog2(WIN_ROWS);
  localparam int WIN_SIZE = WIN_ROWS * WIN_COLS;
  localparam int TW       = $clog2(WIN_SIZE * MAG_MAX + 1);

  // Size registers and their effective values
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;

  // Position of the next pixel; slot_pos tracks row_pos modulo WIN_ROWS
  logic [CW-1:0]    col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [SW-1:0]    slot_pos;

  logic          accept;
  logic [WW-1:0] c0, c1, cn;
  logic [HW-1:0] r0, r1, r2, rn;
  logic [SW-1:0] s0, s1, s2, sn;
  logic          win;
  logic [HW-1:0] brow_full;
  logic [WW-1:0] bcol_full;
  meta_t         meta_in;

  // Pipeline stages
  logic             p1_valid, p2_valid, p3_valid, p4_valid;
  logic [CW-1:0]    p1_col;
  logic [SW-1:0]    p1_slot;
  logic [MAG_W-1:0] p1_mag;
  meta_t            p1_meta, p2_meta, p3_meta, p4_meta;

  logic [VW-1:0]    vsum;
  logic [VW-1:0]    vs_chain   [WIN_COLS+1];
  logic [TW-1:0]    part_chain [WIN_COLS+1];
  logic [BETA_W-1:0] q;

  // Result queue and the count of beats in flight or queued
  result_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW:0] wptr, rptr;
  logic [FIFO_AW:0] credit;
  logic             out_fire;
  result_t          head;
  result_t          push_data;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(WIN_ROWS - 1)) ? '0 : s + SW'(1);
  endfunction

  // ---------------------------------------------------------------- configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(DIM_RESET);
      image_height <= CFG_W'(DIM_RESET);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize clips to the largest image
  always_comb begin
    eff_w = WW'(image_width);
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (WW'(image_width) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end
    eff_h = HW'(image_height);
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (HW'(image_height) > HW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end
  end

  // ---------------------------------------------------------------- position
  assign accept       = pixels.valid && pixels.ready;
  assign pixels.ready = credit < (FIFO_AW+1)'(FIFO_DEPTH);

  always_comb begin
    c0 = pixels.start_image ? '0 : WW'(col_pos);
    r0 = pixels.start_image ? '0 : HW'(row_pos);
    s0 = pixels.start_image ? '0 : slot_pos;
    // Wrap a position left outside a shrunken image
    c1 = c0;
    r1 = r0;
    s1 = s0;
    if (c0 >= eff_w) begin
      c1 = '0;
      r1 = r0 + HW'(1);
      s1 = slot_inc(s0);
    end
    r2 = r1;
    s2 = s1;
    if (r1 >= eff_h) begin
      r2 = '0;
      s2 = '0;
    end
    // Advance past this pixel
    cn = c1 + WW'(1);
    rn = r2;
    sn = s2;
    if (cn >= eff_w) begin
      cn = '0;
      rn = r2 + HW'(1);
      sn = slot_inc(s2);
      if (rn >= eff_h) begin
        rn = '0;
        sn = '0;
      end
    end
    win       = (r2 >= HW'(WIN_ROWS - 1)) && (c1 >= WW'(WIN_COLS - 1));
    brow_full = r2 - HW'(WIN_ROWS - 1);
    bcol_full = c1 - WW'(WIN_COLS - 1);
    meta_in.sign_negative = pixels.pixel[PIX_W-1];
    meta_in.beta_valid    = win;
    meta_in.beta_row      = win ? brow_full[ROW_W-1:0] : '0;
    meta_in.beta_col      = win ? bcol_full[COL_OUT_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      slot_pos <= '0;
    end else if (accept) begin
      col_pos  <= cn[CW-1:0];
      row_pos  <= rn[ROW_W-1:0];
      slot_pos <= sn;
    end
  end

  // ---------------------------------------------------------------- pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
    p1_col  <= c1[CW-1:0];
    p1_slot <= s2;
    p1_mag  <= magnitude(pixels.pixel);
    p1_meta <= meta_in;
    p2_meta <= p1_meta;
    p3_meta <= p2_meta;
    p4_meta <= p3_meta;
  end

  // Read at the beat, merge and write back in the cycle after it
  bawm_line_store #(
    .WIN_ROWS  (WIN_ROWS),
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .SW        (SW),
    .VW        (VW)
  ) u_line_store (
    .clk      (clk),
    .rst      (rst),
    .rd_col   (c1[CW-1:0]),
    .wr_valid (p1_valid),
    .wr_col   (p1_col),
    .wr_slot  (p1_slot),
    .wr_mag   (p1_mag),
    .vsum     (vsum)
  );

  // Row of column cells: advance the vertical sums one place per pixel
  assign vs_chain[0]   = vsum;
  assign part_chain[0] = '0;

  for (genvar k = 0; k < WIN_COLS; k++) begin : g_cell
    bawm_cell #(
      .VW (VW),
      .TW (TW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (p1_valid),
      .vsum_in  (vs_chain[k]),
      .part_in  (part_chain[k]),
      .vsum_out (vs_chain[k+1]),
      .part_out (part_chain[k+1])
    );
  end

  bawm_mean_div #(
    .WIN_SIZE (WIN_SIZE),
    .TW       (TW)
  ) u_mean_div (
    .clk      (clk),
    .total_in (part_chain[WIN_COLS]),
    .q        (q)
  );

  // ---------------------------------------------------------------- result queue
  always_comb begin
    push_data.sign_negative = p4_meta.sign_negative;
    push_data.beta_valid    = p4_meta.beta_valid;
    push_data.beta          = p4_meta.beta_valid ? q : '0;
    push_data.beta_row      = p4_meta.beta_row;
    push_data.beta_col      = p4_meta.beta_col;
  end

  assign out_fire = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (p4_valid) begin
      fifo_mem[wptr[FIFO_AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= '0;
      rptr   <= '0;
      credit <= '0;
    end else begin
      if (p4_valid) begin
        wptr <= wptr + (FIFO_AW+1)'(1);
      end
      if (out_fire) begin
        rptr <= rptr + (FIFO_AW+1)'(1);
      end
      credit <= credit + (FIFO_AW+1)'(accept) - (FIFO_AW+1)'(out_fire);
    end
  end

  assign head                  = fifo_mem[rptr[FIFO_AW-1:0]];
  assign results.valid         = wptr != rptr;
  assign results.sign_negative = head.sign_negative;
  assign results.beta_valid    = head.beta_valid;
  assign results.beta          = head.beta;
  assign results.beta_row      = head.beta_row;
  assign results.beta_col      = head.beta_col;

endmodule

// ----- rtl/bawm_checker.sv -----
// Port-level assertions on the top level, attached by bind.
module bawm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           beta_valid,
  input logic [bawm_pkg::BETA_W-1:0]    beta,
  input logic [bawm_pkg::ROW_W-1:0]     beta_row,
  input logic [bawm_pkg::COL_OUT_W-1:0] beta_col
);
  import bawm_pkg::*;

  logic [FIFO_AW+1:0] outstanding;
  logic               in_fire;
  logic               out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + (FIFO_AW+2)'(in_fire) - (FIFO_AW+2)'(out_fire);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(beta) && $stable(beta_valid))
    else $error("result beat changed while stalled");

  a_no_window_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !beta_valid |-> beta == '0 && beta_row == '0 && beta_col == '0)
    else $error("window fields not zero without a window");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> outstanding != '0)
    else $error("result beat without a pixel beat");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding >= (FIFO_AW+2)'(FIFO_DEPTH) |-> !in_ready)
    else $error("pixel taken with the result queue committed");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind binary_activation_window_mean_abs bawm_checker u_bawm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (pixels.valid),
  .in_ready   (pixels.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .beta_valid (results.beta_valid),
  .beta       (results.beta),
  .beta_row   (results.beta_row),
  .beta_col   (results.beta_col)
);

// ----- sim/bawm_window_checker.sv -----
// Checker for the binarising window-mean block: predicts every result beat and compares it.
`timescale 1ns / 100ps

module bawm_window_checker (
  input  logic        clk,
  input  logic        rst,
  bawm_pixel_if       pixels,
  bawm_result_if      results,
  bawm_cfg_if         cfg,
  output int unsigned failures,
  output int unsigned outstanding,
  output int unsigned pixel_beats,
  output int unsigned window_beats
);
  import bawm_pkg::*;

  localparam int WIN_R        = DEF_WIN_ROWS;
  localparam int WIN_C        = DEF_WIN_COLS;
  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int REPORT_LIMIT = 10;

  // Predictor state: size registers, magnitude rows, per-column vertical sums, position
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [MAG_W-1:0] mag_store [WIN_R][MAX_W];
  int unsigned      col_sum [WIN_C];
  int unsigned      cur_row;
  int unsigned      cur_col;

  result_t          sign_beta_q[$];

  // Sign bit of the pixel, plus the floored window mean when it closes a window
  function automatic result_t binarise_and_average(input logic [PIX_W-1:0] raw,
                                                   input logic first);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int unsigned k;
    int unsigned vsum;
    int unsigned total;
    logic [16:0] neg;
    logic [MAG_W-1:0] mag;
    result_t res;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (first) begin
      cur_row = 0;
      cur_col = 0;
    end
    // a shrunk width or height pushes the position back into the image
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= h) cur_row = 0;
    r = cur_row;
    c = cur_col;

    neg = 17'h10000 - {1'b0, raw};
    if (!raw[PIX_W-1]) mag = raw[MAG_W-1:0];
    else if (neg > 17'(MAG_MAX)) mag = MAG_W'(MAG_MAX);
    else mag = neg[MAG_W-1:0];

    mag_store[r % WIN_R][c] = mag;
    // the slots hold exactly the last WIN_R rows, so the column sum is over all of them
    vsum = 0;
    for (k = 0; k < WIN_R; k++) vsum += mag_store[k][c];
    col_sum[c % WIN_C] = vsum;

    res = '0;
    res.sign_negative = raw[PIX_W-1];
    if (r >= WIN_R - 1 && c >= WIN_C - 1) begin
      total = 0;
      for (k = 0; k < WIN_C; k++) total += col_sum[k];
      res.beta_valid = 1'b1;
      res.beta       = BETA_W'(total / (WIN_R * WIN_C));
      res.beta_row   = ROW_W'(r - (WIN_R - 1));
      res.beta_col   = COL_OUT_W'(c - (WIN_C - 1));
    end

    cur_col = c + 1;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row = r + 1;
      if (cur_row >= h) cur_row = 0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      width_reg  = CFG_W'(DIM_RESET);
      height_reg = CFG_W'(DIM_RESET);
      for (int s = 0; s < WIN_R; s++)
        for (int x = 0; x < MAX_W; x++) mag_store[s][x] = '0;
      for (int x = 0; x < WIN_C; x++) col_sum[x] = 0;
      cur_row = 0;
      cur_col = 0;
      sign_beta_q.delete();
      failures     = 0;
      pixel_beats  = 0;
      window_beats = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg_reg_t'(cfg.index))
          REG_IMAGE_WIDTH:  width_reg = cfg.data;
          REG_IMAGE_HEIGHT: height_reg = cfg.data;
          default: ;
        endcase
      end
      if (pixels.valid === 1'b1 && pixels.ready === 1'b1) begin
        sign_beta_q.push_back(binarise_and_average(pixels.pixel, pixels.start_image));
        pixel_beats++;
      end
      if (results.valid === 1'b1 && results.ready === 1'b1) begin
        got.sign_negative = results.sign_negative;
        got.beta_valid    = results.beta_valid;
        got.beta          = results.beta;
        got.beta_row      = results.beta_row;
        got.beta_col      = results.beta_col;
        if (sign_beta_q.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display({"%0t: result beat with nothing predicted: ",
                      "sign=%b win=%b beta=%0d row=%0d col=%0d"},
                     $realtime, got.sign_negative, got.beta_valid, got.beta, got.beta_row,
                     got.beta_col);
        end else begin
          want = sign_beta_q.pop_front();
          if (got.sign_negative !== want.sign_negative || got.beta_valid !== want.beta_valid ||
              got.beta !== want.beta || got.beta_row !== want.beta_row ||
              got.beta_col !== want.beta_col) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected sign=%b win=%b beta=%0d row=%0d col=%0d", want.sign_negative,
                       want.beta_valid, want.beta, want.beta_row, want.beta_col);
              $display("  actual   sign=%b win=%b beta=%0d row=%0d col=%0d", got.sign_negative,
                       got.beta_valid, got.beta, got.beta_row, got.beta_col);
            end
          end else if (want.beta_valid) begin
            window_beats++;
          end
        end
      end
    end
    outstanding = sign_beta_q.size();
  end

endmodule

// ----- sim/tb_binary_activation_window_mean_abs.sv -----
// Testbench top: drives pixels, size writes and result stalls, and gives the verdict.
`timescale 1ns / 100ps

module tb_binary_activation_window_mean_abs;
  import bawm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // margin after the last result has drained, before touching the size registers
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // Extremes of the pixel field, each bit pattern both ways, fed into the first row
  localparam logic [PIX_W-1:0] EDGE_PIXELS [20] = '{
    16'h8000, 16'h7FFF, 16'h8001, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000, 16'hC000,
    16'h5555, 16'hAAAA, 16'h7FFE, 16'h8002, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
    16'h3FFF, 16'hBFFF, 16'h1234, 16'hEDCC
  };

  // 3x3 images: a full-scale window, a saturating and flooring window with no start flag
  // ahead of it, then a restart in the middle of an image
  localparam logic [PIX_W-1:0] WINDOW_PIXELS [21] = '{
    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
    16'h7FFF,
    16'h8000, 16'h8001, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000, 16'hC000,
    16'h1234,
    16'h0005, 16'hFFF9, 16'h0000
  };
  localparam bit WINDOW_STARTS [21] = '{
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b0, 1'b1
  };

  logic clk = 1'b0;
  logic rst;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          image_px;
  int          px_in_image;
  int          settings_run;
  int unsigned cycle_count;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixel_count;
  int unsigned window_count;

  bawm_pixel_if  pix_ch ();
  bawm_result_if res_ch ();
  bawm_cfg_if    cfg_ch ();

  binary_activation_window_mean_abs DUT (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  bawm_window_checker mean_check (
    .clk          (clk),
    .rst          (rst),
    .pixels       (pix_ch),
    .results      (res_ch),
    .cfg          (cfg_ch),
    .failures     (fail_count),
    .outstanding  (pending),
    .pixel_beats  (pixel_count),
    .window_beats (window_count)
  );

  always #6 clk = ~clk;

  // Result side: drop ready at random, at the rate the current phase asks for
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Mostly random codes, with a heavy share of the extremes and of tiny magnitudes
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h8001;
      3: return 16'h0000;
      4: return PIX_W'($urandom_range(6)) - PIX_W'(3);
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Offer one pixel beat, after an optional random gap; hold it until accepted
  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel       <= pix;
    pix_ch.start_image <= first;
    @(posedge clk);
    while (pix_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write beat; lower valid before the next write may start
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending, wait for every predicted beat, then let the pipeline settle
  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // New size setting: only written once the block has gone quiet
  task automatic setup_phase(input int w, input int h, input idle_mode_t mode);
    int eff_w;
    int eff_h;
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
    settings_run++;
    eff_w = (w == 0) ? 1 : (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
    eff_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    image_px    = eff_w * eff_h;
    px_in_image = 0;
    case (mode)
      IDLE_SEND: begin
        send_idle_pct  = 46;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 46;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 25;
        recv_stall_pct = 25;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Random pixels in raster order. With restarts, most images open with a start flag,
  // some run straight on through the wrap, and a rare flag breaks an image midway.
  task automatic stream_pixels(input int count, input bit start_first, input bit restarts);
    bit first;
    for (int k = 0; k < count; k++) begin
      if (k == 0) first = start_first;
      else if (restarts && px_in_image == 0) first = ($urandom_range(3) != 0);
      else first = restarts && ($urandom_range(149) == 0);
      if (first) px_in_image = 0;
      push_pixel(random_pixel(), first);
      px_in_image = (px_in_image + 1) % image_px;
    end
  endtask

  // Bound the run; a hang anywhere ends here
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped by the watchdog after %0d cycles, %0d beats still due",
             cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    pix_ch.valid       = 1'b0;
    pix_ch.pixel       = '0;
    pix_ch.start_image = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_IMAGE_WIDTH;
    cfg_ch.data        = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    image_px           = DIM_RESET * DIM_RESET;
    px_in_image        = 0;
    settings_run       = 1;
    rst                = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset sizes (28x28): edge codes open row 0, random data carries on through row 3 col 15
    for (int k = 0; k < 20; k++) push_pixel(EDGE_PIXELS[k], k == 0);
    stream_pixels(80, 1'b0, 1'b0);

    // Shrink the width below the current column, then the height below the current row:
    // both positions must wrap with no start flag
    setup_phase(10, 28, IDLE_SEND);
    stream_pixels(40, 1'b0, 1'b0);
    setup_phase(10, 3, IDLE_RECV);
    stream_pixels(60, 1'b0, 1'b0);

    // Hand-built 3x3 windows
    setup_phase(3, 3, IDLE_NONE);
    for (int k = 0; k < 21; k++) push_pixel(WINDOW_PIXELS[k], WINDOW_STARTS[k]);

    // Small images, and images too small for any window
    setup_phase(5, 4, IDLE_BOTH);
    stream_pixels(100, 1'b1, 1'b1);
    setup_phase(7, 6, IDLE_SEND);
    stream_pixels(100, 1'b1, 1'b1);
    setup_phase(1, 9, IDLE_RECV);
    stream_pixels(40, 1'b1, 1'b1);
    setup_phase(9, 1, IDLE_BOTH);
    stream_pixels(40, 1'b1, 1'b1);
    setup_phase(0, 0, IDLE_NONE);
    stream_pixels(30, 1'b1, 1'b1);
    setup_phase(2, 5, IDLE_SEND);
    stream_pixels(40, 1'b1, 1'b1);

    // Oversize width and oversize height: a short stretch of the first row, then of the first rows
    setup_phase(2047, 3, IDLE_RECV);
    stream_pixels(40, 1'b1, 1'b0);
    setup_phase(3, 2047, IDLE_BOTH);
    stream_pixels(40, 1'b1, 1'b0);
    // Largest in-range values, a short stretch of the first row only
    setup_phase(1024, 1024, IDLE_SEND);
    stream_pixels(40, 1'b1, 1'b1);

    setup_phase(4, 3, IDLE_RECV);
    stream_pixels(80, 1'b1, 1'b1);
    setup_phase(11, 7, IDLE_BOTH);
    stream_pixels(100, 1'b1, 1'b1);
    setup_phase(28, 28, IDLE_NONE);
    stream_pixels(80, 1'b1, 1'b1);

    drain();

    $display("Covered %0d pixel beats, %0d of them closing a window, over %0d size settings",
             pixel_count, window_count, settings_run);
    $display("Sizes from 0 to 2047 on both registers, with sender gaps and result stalls");
    if (pending != 0) $display("%0d predicted beats never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bawm_pkg.sv
rtl/bawm_pixel_if.sv
rtl/bawm_result_if.sv
rtl/bawm_cfg_if.sv
rtl/bawm_line_store.sv
rtl/bawm_cell.sv
rtl/bawm_mean_div.sv
rtl/binary_activation_window_mean_abs.sv
rtl/bawm_checker.sv
sim/bawm_window_checker.sv
sim/tb_binary_activation_window_mean_abs.sv
